>>> rtl/cwq_pkg.sv
// Shared types and constants for the two-class weighted queue.
// Used by the front, back and top-level modules.
`default_nettype none

package cwq_pkg;

    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int BURST_W = 4;

    localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
    localparam logic [BURST_W-1:0] BURST_RESET = 4'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic {
        CFG_TOTAL_CAPACITY = 1'b0,
        CFG_BURST_LIMIT    = 1'b1
    } cfg_idx_t;

    // Command handed from the front to the back
    typedef struct packed {
        status_t status;
        logic    wr;
        logic    rd;
        logic    sel_high;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

endpackage

`default_nettype wire

>>> rtl/cwq_front.sv
// Front end: accepts words, holds the FIFO pointers, counts, burst state and config,
// and turns each word into a memory command. Depends on cwq_pkg.
`default_nettype none

module cwq_front
    import cwq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [CAP_W-1:0]             cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         in_op,
    input  wire logic [DATA_W-1:0]            in_data,
    input  wire logic                         in_high,
    input  wire logic                         push_ready,
    output logic                              push_valid,
    output ctl_t                              push_ctl,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] push_addr,
    output logic [DATA_W-1:0]                 push_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]   cap_reg;
    logic [BURST_W-1:0] burst_lim_reg;

    logic [PTR_W-1:0]   high_head_reg, high_head_next;
    logic [PTR_W-1:0]   high_tail_reg, high_tail_next;
    logic [CNT_W-1:0]   high_cnt_reg, high_cnt_next;
    logic [PTR_W-1:0]   norm_head_reg, norm_head_next;
    logic [PTR_W-1:0]   norm_tail_reg, norm_tail_next;
    logic [CNT_W-1:0]   norm_cnt_reg, norm_cnt_next;
    logic [BURST_W-1:0] burst_reg, burst_next;

    logic               accept;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   used;
    logic               full;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;
    assign push_valid = accept;
    assign push_data  = in_data;

    // capacity above the FIFO depth acts as the depth
    assign cap_ext = CMP_W'(cap_reg);
    assign cap_eff = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign used    = CMP_W'(high_cnt_reg) + CMP_W'(norm_cnt_reg);
    assign full    = (used >= cap_eff);

    always_comb
    begin
        high_head_next = high_head_reg;
        high_tail_next = high_tail_reg;
        high_cnt_next  = high_cnt_reg;
        norm_head_next = norm_head_reg;
        norm_tail_next = norm_tail_reg;
        norm_cnt_next  = norm_cnt_reg;
        burst_next     = burst_reg;
        push_ctl       = '{status: ST_OK, wr: 1'b0, rd: 1'b0, sel_high: 1'b0};
        push_addr      = '0;

        if (in_op == OP_ENQ)
        begin
            if (full)
            begin
                push_ctl.status = ST_FULL;
            end
            else if (in_high)
            begin
                push_ctl.wr       = 1'b1;
                push_ctl.sel_high = 1'b1;
                push_addr         = high_tail_reg;
                high_tail_next    = ring_next(high_tail_reg);
                high_cnt_next     = high_cnt_reg + CNT_W'(1);
            end
            else
            begin
                push_ctl.wr    = 1'b1;
                push_addr      = norm_tail_reg;
                norm_tail_next = ring_next(norm_tail_reg);
                norm_cnt_next  = norm_cnt_reg + CNT_W'(1);
            end
        end
        else
        begin
            if ((high_cnt_reg != '0) && (burst_reg < burst_lim_reg))
            begin
                push_ctl.rd       = 1'b1;
                push_ctl.sel_high = 1'b1;
                push_addr         = high_head_reg;
                high_head_next    = ring_next(high_head_reg);
                high_cnt_next     = high_cnt_reg - CNT_W'(1);
                burst_next        = burst_reg + BURST_W'(1);
            end
            else if (norm_cnt_reg != '0)
            begin
                push_ctl.rd    = 1'b1;
                push_addr      = norm_head_reg;
                norm_head_next = ring_next(norm_head_reg);
                norm_cnt_next  = norm_cnt_reg - CNT_W'(1);
                burst_next     = '0;
            end
            else if (high_cnt_reg != '0)
            begin
                // burst spent but no normal word waiting: serve high, hold the burst count
                push_ctl.rd       = 1'b1;
                push_ctl.sel_high = 1'b1;
                push_addr         = high_head_reg;
                high_head_next    = ring_next(high_head_reg);
                high_cnt_next     = high_cnt_reg - CNT_W'(1);
            end
            else
            begin
                push_ctl.status = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_head_reg <= '0;
            high_tail_reg <= '0;
            high_cnt_reg  <= '0;
            norm_head_reg <= '0;
            norm_tail_reg <= '0;
            norm_cnt_reg  <= '0;
            burst_reg     <= '0;
        end
        else if (accept)
        begin
            high_head_reg <= high_head_next;
            high_tail_reg <= high_tail_next;
            high_cnt_reg  <= high_cnt_next;
            norm_head_reg <= norm_head_next;
            norm_tail_reg <= norm_tail_next;
            norm_cnt_reg  <= norm_cnt_next;
            burst_reg     <= burst_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            burst_lim_reg <= BURST_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TOTAL_CAPACITY: cap_reg       <= cfg_data;
                CFG_BURST_LIMIT:    burst_lim_reg <= cfg_data[BURST_W-1:0];
                default:            ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/cwq_cmdq.sv
// Two-entry command queue between the front and the back.
// Generic width; no package dependency.
`default_nettype none

module cwq_cmdq
#(
    parameter int W = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output logic [W-1:0]      pop_data
);

    logic [W-1:0] ent_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         push;
    logic         pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = ent_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> rtl/cwq_back.sv
// Back end: the two FIFO memories and the output register.
// Executes one command per cycle in order while the output is not stalled. Depends on cwq_pkg.
`default_nettype none

module cwq_back
    import cwq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire ctl_t                       cmd_ctl,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] cmd_addr,
    input  wire logic [DATA_W-1:0]          cmd_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output status_t                         out_status,
    output logic [DATA_W-1:0]               out_data,
    output logic                            out_high
);

    logic [DATA_W-1:0] high_mem [DEPTH];
    logic [DATA_W-1:0] norm_mem [DEPTH];

    logic              valid_reg;
    status_t           status_reg;
    logic [DATA_W-1:0] data_reg;
    logic              high_reg;
    logic              pop;

    assign cmd_ready  = !valid_reg || out_ready;
    assign pop        = cmd_valid && cmd_ready;
    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_data   = data_reg;
    assign out_high   = high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd_ready)
            valid_reg <= cmd_valid;
    end

    // memory write and registered read straight into the output word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cmd_ctl.wr && cmd_ctl.sel_high)
                high_mem[cmd_addr] <= cmd_data;
            if (cmd_ctl.wr && !cmd_ctl.sel_high)
                norm_mem[cmd_addr] <= cmd_data;

            if (cmd_ctl.rd)
                data_reg <= cmd_ctl.sel_high ? high_mem[cmd_addr] : norm_mem[cmd_addr];
            else
                data_reg <= '0;

            status_reg <= cmd_ctl.status;
            high_reg   <= cmd_ctl.rd && cmd_ctl.sel_high;
        end
    end

endmodule

`default_nettype wire

>>> rtl/two_class_weighted_queue_top.sv
// Two-class weighted queue: high and normal FIFOs sharing one capacity.
// Throughput: one word per cycle while the output is not stalled; each word makes exactly one result word.
// m_tvalid rises once an accepted word has passed the command queue and then the memory read.
// Input and output sides are decoupled by a two-entry command queue and an output register.
// Reset: counts, pointers and burst count cleared, capacity 16, burst limit 3;
// the FIFO memories are not cleared and need no clearing pass.
`default_nettype none

module two_class_weighted_queue_top
    import cwq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DATA_W-1:0]  s_tdata,   // data_in
    input  wire logic [1:0]         s_tuser,   // op, high_class
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [DATA_W-1:0]       m_tdata,   // data_out
    output logic [2:0]              m_tuser,   // status[1:0], served_high
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [CAP_W-1:0]   cfg_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int Q_W   = DATA_W + PTR_W + CTL_W;

    logic              push_valid;
    logic              push_ready;
    ctl_t              push_ctl;
    logic [PTR_W-1:0]  push_addr;
    logic [DATA_W-1:0] push_data;

    logic              q_pop_valid;
    logic              q_pop_ready;
    logic [Q_W-1:0]    q_pop_data;
    logic              q_pop;

    ctl_t              cmd_ctl;
    logic [PTR_W-1:0]  cmd_addr;
    logic [DATA_W-1:0] cmd_data;

    status_t           out_status;
    logic              out_high;

    assign cfg_ready = 1'b1;

    cwq_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser[0]),
        .in_data    (s_tdata),
        .in_high    (s_tuser[1]),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_ctl   (push_ctl),
        .push_addr  (push_addr),
        .push_data  (push_data)
    );

    cwq_cmdq #(
        .W (Q_W)
    ) u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_data, push_addr, push_ctl}),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    assign cmd_ctl  = ctl_t'(q_pop_data[CTL_W-1:0]);
    assign cmd_addr = q_pop_data[CTL_W +: PTR_W];
    assign cmd_data = q_pop_data[CTL_W + PTR_W +: DATA_W];
    assign q_pop    = q_pop_valid && q_pop_ready;

    cwq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_pop_valid),
        .cmd_ready  (q_pop_ready),
        .cmd_ctl    (cmd_ctl),
        .cmd_addr   (cmd_addr),
        .cmd_data   (cmd_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_data   (m_tdata),
        .out_high   (out_high)
    );

    assign m_tuser = {out_high, out_status};

    // a dequeue never turns into a memory write
    a_deq_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && (s_tuser[0] == OP_DEQ)) |-> !push_ctl.wr)
        else $error("dequeue produced a write command");

    // full or empty results carry a zero word and no high flag
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_status != ST_OK)) |-> ((m_tdata == '0) && !out_high))
        else $error("non-ok result with data");

    // a new result only appears after a command left the queue
    a_out_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_pop))
        else $error("result without command");

endmodule

`default_nettype wire

>>> tb/two_class_weighted_queue_top_tb.sv
// Testbench for two_class_weighted_queue_top: random and directed enqueue/dequeue words
// are checked against an in-bench model of the two shared-capacity FIFOs.
// Depends on cwq_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module two_class_weighted_queue_top_tb;
    import cwq_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int WDOG_LIMIT = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int PHASES     = 9;
    localparam int PHASE_LEN  = 160;

    typedef struct packed {
        op_t         op;
        logic [31:0] data;
        logic        high_class;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] data;
        logic        served_high;
    } resp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata = '0;
    logic [1:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [DATA_W-1:0]  m_tdata;
    logic [2:0]         m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index = '0;
    logic [CAP_W-1:0]   cfg_data = '0;

    two_class_weighted_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state
    logic [31:0]        hi_mem [QDEPTH];
    logic [31:0]        nm_mem [QDEPTH];
    logic [3:0]         hi_head = '0, hi_tail = '0, nm_head = '0, nm_tail = '0;
    int                 hi_cnt = 0, nm_cnt = 0;
    logic [3:0]         burst_cnt = '0;
    logic [CAP_W-1:0]   cap_cfg = CAP_RESET;
    logic [BURST_W-1:0] burst_cfg = BURST_RESET;

    req_t  pending_words[$];
    resp_t due_results[$];
    req_t  cur_word;
    int    queued_cnt = 0;
    int    checked_cnt = 0;
    int    err_cnt = 0;
    int    send_idle_pct = 26;
    int    recv_idle_pct = 48;
    int    hold_req = 0;
    int    hold_ack = 0;
    int    hold_left = 0;
    int    idle_cycles = 0;

    function automatic resp_t queue_model_step(input req_t w);
        resp_t r;
        int    lim;
        r.status      = ST_OK;
        r.data        = '0;
        r.served_high = 1'b0;
        if (w.op == OP_ENQ)
        begin
            lim = (int'(cap_cfg) > QDEPTH) ? QDEPTH : int'(cap_cfg);
            if (hi_cnt + nm_cnt >= lim)
                r.status = ST_FULL;
            else if (w.high_class)
            begin
                hi_mem[hi_tail] = w.data;
                hi_tail         = hi_tail + 4'd1;
                hi_cnt++;
            end
            else
            begin
                nm_mem[nm_tail] = w.data;
                nm_tail         = nm_tail + 4'd1;
                nm_cnt++;
            end
        end
        else
        begin
            if (hi_cnt > 0 && burst_cnt < burst_cfg)
            begin
                r.data        = hi_mem[hi_head];
                r.served_high = 1'b1;
                hi_head       = hi_head + 4'd1;
                hi_cnt--;
                burst_cnt     = burst_cnt + 4'd1;
            end
            else if (nm_cnt > 0)
            begin
                r.data    = nm_mem[nm_head];
                nm_head   = nm_head + 4'd1;
                nm_cnt--;
                burst_cnt = '0;
            end
            else if (hi_cnt > 0)
            begin
                // burst spent, normal empty: serve high, burst count held
                r.data        = hi_mem[hi_head];
                r.served_high = 1'b1;
                hi_head       = hi_head + 4'd1;
                hi_cnt--;
            end
            else
                r.status = ST_EMPTY;
        end
        return r;
    endfunction

    task automatic push_word(input op_t op, input logic [31:0] data, input logic hc);
        req_t w;
        w.op         = op;
        w.data       = data;
        w.high_class = hc;
        pending_words.push_back(w);
        queued_cnt++;
    endtask

    // Runs of enqueue-heavy and dequeue-heavy traffic so both FIFOs fill and drain
    task automatic push_random_words(input int n);
        int run_len;
        int enq_pct;
        int hi_pct;
        while (n > 0)
        begin
            run_len = $urandom_range(8, 40);
            case ($urandom_range(0, 3))
                0: enq_pct = 20;
                1: enq_pct = 50;
                2: enq_pct = 80;
                default: enq_pct = $urandom_range(0, 100);
            endcase
            hi_pct = $urandom_range(0, 100);
            for (int i = 0; i < run_len && n > 0; i++)
            begin
                push_word(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ, $urandom,
                          ($urandom_range(0, 99) < hi_pct));
                n--;
            end
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CAP_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_TOTAL_CAPACITY)
            cap_cfg = val;
        else
            burst_cfg = val[BURST_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (checked_cnt != queued_cnt)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                due_results.push_back(queue_model_step(cur_word));
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_word.data;
                    s_tuser  <= {cur_word.high_class, cur_word.op};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output ready, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Output monitor
    always @(posedge clk)
    begin : monitor
        resp_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            checked_cnt++;
            if (due_results.size() == 0)
            begin
                $error("unexpected result word: status %0d data %h served_high %0b",
                       m_tuser[1:0], m_tdata, m_tuser[2]);
                err_cnt++;
            end
            else
            begin
                exp_w = due_results.pop_front();
                if (m_tuser[1:0] !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, m_tuser[1:0]);
                    err_cnt++;
                end
                if (m_tdata !== exp_w.data)
                begin
                    $error("data_out: expected %h, got %h", exp_w.data, m_tdata);
                    err_cnt++;
                end
                if (m_tuser[2] !== exp_w.served_high)
                begin
                    $error("served_high: expected %0b, got %0b", exp_w.served_high,
                           m_tuser[2]);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("two_class_weighted_queue_top_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [CAP_W-1:0]   cap_set [PHASES];
        logic [BURST_W-1:0] burst_set [PHASES];
        cap_set   = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd16, 5'd9, 5'd2, 5'd16, 5'd12};
        burst_set = '{4'd3, 4'd15, 4'd0, 4'd1, 4'd15, 4'd5, 4'd0, 4'd2, 4'd7};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: empty dequeue, extreme words, burst of three then one normal
        push_word(OP_DEQ, 32'hffff_ffff, 1'b1);
        push_word(OP_ENQ, 32'hffff_ffff, 1'b1);
        push_word(OP_ENQ, 32'h0000_0000, 1'b1);
        push_word(OP_ENQ, 32'ha5a5_5a5a, 1'b1);
        push_word(OP_ENQ, 32'h8000_0001, 1'b1);
        push_word(OP_ENQ, 32'h0000_0000, 1'b0);
        push_word(OP_ENQ, 32'hffff_ffff, 1'b0);
        repeat (6) push_word(OP_DEQ, 32'h0, 1'b0);
        push_word(OP_DEQ, 32'h0, 1'b0);
        wait_drained();

        // Zero capacity
        write_reg(CFG_TOTAL_CAPACITY, 5'd0);
        push_word(OP_ENQ, 32'h1234_5678, 1'b1);
        push_word(OP_DEQ, 32'h0, 1'b1);
        wait_drained();

        // Capacity two, zero burst: normal first, then high with burst spent
        write_reg(CFG_TOTAL_CAPACITY, 5'd2);
        write_reg(CFG_BURST_LIMIT, 5'd0);
        push_word(OP_ENQ, 32'h1111_1111, 1'b1);
        push_word(OP_ENQ, 32'h2222_2222, 1'b0);
        push_word(OP_ENQ, 32'h3333_3333, 1'b1);
        push_word(OP_DEQ, 32'h0, 1'b0);
        push_word(OP_DEQ, 32'h0, 1'b0);
        wait_drained();

        // Burst limit lowered below the running burst count
        write_reg(CFG_TOTAL_CAPACITY, 5'd16);
        write_reg(CFG_BURST_LIMIT, 5'd5);
        repeat (3) push_word(OP_ENQ, $urandom, 1'b1);
        repeat (3) push_word(OP_DEQ, 32'h0, 1'b0);
        wait_drained();
        write_reg(CFG_BURST_LIMIT, 5'd1);
        push_word(OP_ENQ, 32'h5555_aaaa, 1'b0);
        push_word(OP_ENQ, 32'haaaa_5555, 1'b1);
        push_word(OP_DEQ, 32'h0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 48;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_TOTAL_CAPACITY, cap_set[ph]);
            // bit above the burst field is ignored by the block
            write_reg(CFG_BURST_LIMIT, {1'($urandom_range(0, 1)), burst_set[ph]});
            if (ph == 1)
                hold_req++;
            push_random_words(PHASE_LEN);
            wait_drained();
        end

        if (due_results.size() != 0)
        begin
            $error("%0d result words never arrived", due_results.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("two_class_weighted_queue_top_tb: PASS");
        else
            $display("two_class_weighted_queue_top_tb: FAIL");
        $finish;
    end

endmodule
